/* hw/rtl/svfm_pkg.sv */
`default_nettype none
package svfm_pkg;

	localparam int ExpBits = 29;
	localparam int QBits = 31;

	typedef logic [63:0] exp_tab_t [ExpBits];
	typedef logic [31:0] coef_pair_t [2];

	localparam logic [31:0] ONE31 = 32'h8000_0000;
	localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;

	localparam logic [1:0] MethodConst = 2'd0;
	localparam logic [1:0] MethodMid = 2'd1;
	localparam logic [1:0] MethodCd = 2'd2;
	localparam logic [1:0] MethodHmd = 2'd3;

	localparam logic [1:0] CfgMethod = 2'd0;
	localparam logic [1:0] CfgSex = 2'd1;
	localparam logic [1:0] CfgSep = 2'd2;

	localparam logic [2:0] AgeInfant = 3'd0;
	localparam logic [2:0] AgeOneFour = 3'd1;
	localparam logic [2:0] AgeSingle = 3'd2;
	localparam logic [2:0] AgeFive = 3'd3;

	// thresholds q8.24, values and slopes q2.30, index 0 female 1 male
	localparam logic [31:0] CD_THR = 32'd1795162;
	localparam coef_pair_t CD_HI = '{32'd375809638, 32'd354334802};
	localparam coef_pair_t CD_C0 = '{32'd56908317, 32'd48318382};
	localparam coef_pair_t CD_SL = '{32'd3006477107, 32'd2881923056};
	localparam coef_pair_t HMD_THR1 = '{32'd1156118, 32'd1393683};
	localparam coef_pair_t HMD_THR2 = '{32'd289239, 32'd385876};
	localparam coef_pair_t HMD_HI = '{32'd337273044, 32'd321209867};
	localparam coef_pair_t HMD_CM = '{32'd50111531, 32'd30408368};
	localparam coef_pair_t HMD_SM = '{32'd4167073907, 32'd3500623832};
	localparam coef_pair_t HMD_CL = '{32'd160019744, 32'd160298917};
	localparam coef_pair_t HMD_SL = '{32'd2206829359, 32'd2142598123};

	// exp(-2^(b-24)) in q2.62, alternating series then squaring
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] term;
		logic [63:0] sum;
		logic [127:0] pr;
		int s;
		for (int b = 0; b <= 24; b++) begin
			s = 24 - b;
			term = ONE62;
			sum = ONE62;
			for (int k = 1; k <= 25; k++) begin
				term = (term >> s) / 64'(k);
				if (k % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			tab[b] = sum;
		end
		for (int b = 25; b < ExpBits; b++) begin
			pr = {64'd0, tab[b-1]} * {64'd0, tab[b-1]};
			tab[b] = pr[125:62];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

/* hw/rtl/survivorship_from_mortality_rates.sv */
// Life-table survivorship per column from one mortality rate per age group.
// Input stream s_*: one item per rate; s_tready is high only while no item is
// being worked on. Output stream m_*: one item per input item, in order.
// Configuration: cfg_we, cfg_index, cfg_data; the user writes only while idle (unchecked).
// Survivorship of every column sits in one synchronous memory; an item reads
// it, works out the new value and writes it back before the next item is
// taken, so no two items touch the memory at once.
// The q rules wait on the restoring divider; the constant-hazard rule waits on
// the 4-product 64x64 multiplier once per set bit of n*m (at most 29 bits) and
// once more for the final product; infinite rates, error groups, q of one and
// n*m of 32 or more use neither unit.
// One item is worked on at a time; the next item can be accepted in the same
// cycle that the output goes valid.
// The result waits in an output register, so the next item is accepted while
// it is not yet taken; a stall only holds an item at its final write-back.
// Reset clears control and configuration state, not the datapath registers or
// the survivorship memory; the user starts every column with a first_row item.
`default_nettype none
module survivorship_from_mortality_rates #(
	parameter int NUM_COLUMNS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // column, mortality_rate
	input  wire logic [4:0]  s_tuser,   // age_group, first_row, rate_infinite
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // out_column, survivorship
	output logic             m_tuser,   // group_error
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_READ = 4'd1;
	localparam logic [3:0] ST_PREP = 4'd2;
	localparam logic [3:0] ST_DEN = 4'd3;
	localparam logic [3:0] ST_CHOOSE = 4'd4;
	localparam logic [3:0] ST_DIVW = 4'd5;
	localparam logic [3:0] ST_SCALE = 4'd6;
	localparam logic [3:0] ST_SCALEF = 4'd7;
	localparam logic [3:0] ST_EXP = 4'd8;
	localparam logic [3:0] ST_EXPW = 4'd9;
	localparam logic [3:0] ST_EXPF = 4'd10;
	localparam logic [3:0] ST_EXPFW = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	logic [3:0] state_q;

	logic [1:0]         method_q;
	logic               sex_q;
	logic signed [31:0] a0_q;

	logic [2:0]  age_q;
	logic [5:0]  col_q;
	logic        first_q;
	logic        inf_q;
	logic [31:0] m_q;
	logic        in_range_q;
	logic [31:0] rdata_q;
	logic [31:0] prior_q;
	logic [63:0] sl_prod_s1;
	logic [26:0] d24_q;
	logic [34:0] x_q;
	logic        use_exp_q;
	logic [58:0] den_prod_s1;
	logic [svfm_pkg::QBits-1:0] q_q;
	logic [62:0] scale_s1;
	logic [63:0] p_q;
	logic [4:0]  b_q;
	logic [31:0] res_q;
	logic        err_q;
	logic        wr_q;

	logic        out_valid_q;
	logic [5:0]  out_col_q;
	logic [31:0] out_surv_q;
	logic        out_err_q;

	logic [31:0] surv_mem [NUM_COLUMNS];

	logic        accept;
	logic        out_free;
	logic        mem_we;
	logic [2:0]  n_w;
	logic        infant;
	logic [31:0] slope;
	logic [31:0] tprod;
	logic [31:0] frm;
	logic signed [34:0] a30;
	logic signed [34:0] d30;
	logic [34:0] x_w;
	logic [59:0] num;
	logic [59:0] den;
	logic        num_ge;
	logic [28:0] xl;
	logic        mul_start;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic        mul_done;
	logic [63:0] mul_res;
	logic        div_start;
	logic        div_done;
	logic [svfm_pkg::QBits-1:0] div_quot;

	assign accept = s_tvalid && s_tready;
	assign s_tready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || m_tready;
	assign mem_we = state_q == ST_DONE && out_free && wr_q;
	assign infant = age_q == svfm_pkg::AgeInfant;
	assign xl = x_q[28:0];

	always_comb begin
		case (age_q)
			svfm_pkg::AgeOneFour: n_w = 3'd4;
			svfm_pkg::AgeFive: n_w = 3'd5;
			default: n_w = 3'd1;
		endcase
		case (age_q)
			svfm_pkg::AgeOneFour: x_w = {1'b0, m_q, 2'b00};
			svfm_pkg::AgeFive: x_w = {1'b0, m_q, 2'b00} + {3'b000, m_q};
			default: x_w = {3'b000, m_q};
		endcase
	end

	// separation factor a (configured a0, infant formulas or n/2) and n - a
	always_comb begin
		if (method_q == svfm_pkg::MethodCd) begin
			slope = svfm_pkg::CD_SL[sex_q];
		end else if (m_q >= svfm_pkg::HMD_THR2[sex_q]) begin
			slope = svfm_pkg::HMD_SM[sex_q];
		end else begin
			slope = svfm_pkg::HMD_SL[sex_q];
		end
		tprod = sl_prod_s1[55:24];
		if (method_q == svfm_pkg::MethodCd) begin
			frm = (m_q >= svfm_pkg::CD_THR) ? svfm_pkg::CD_HI[sex_q]
				: svfm_pkg::CD_C0[sex_q] + tprod;
		end else if (m_q >= svfm_pkg::HMD_THR1[sex_q]) begin
			frm = svfm_pkg::HMD_HI[sex_q];
		end else if (m_q >= svfm_pkg::HMD_THR2[sex_q]) begin
			frm = svfm_pkg::HMD_CM[sex_q] + tprod;
		end else begin
			frm = svfm_pkg::HMD_CL[sex_q] - tprod;
		end
		if (method_q == svfm_pkg::MethodConst) begin
			a30 = {{3{a0_q[31]}}, a0_q};
		end else if (infant && !a0_q[31]) begin
			a30 = {{3{a0_q[31]}}, a0_q};
		end else if (infant && (method_q == svfm_pkg::MethodCd ||
				method_q == svfm_pkg::MethodHmd)) begin
			a30 = $signed({3'b000, frm});
		end else begin
			a30 = $signed({3'b000, n_w, 29'd0});
		end
		d30 = $signed({2'b00, n_w, 30'd0}) - a30;
	end

	assign num = {1'b0, x_q, 24'd0};
	assign den = 60'(den_prod_s1) + (60'd1 << 48);
	assign num_ge = num >= den;

	assign mul_start = (state_q == ST_EXP && xl[b_q]) || state_q == ST_EXPF;
	assign mul_a = p_q;
	assign mul_b = (state_q == ST_EXPF) ? {32'd0, prior_q} : svfm_pkg::EXP_TAB[b_q];
	assign div_start = state_q == ST_CHOOSE && in_range_q && age_q[2] == 1'b0 &&
		!inf_q && !use_exp_q && !num_ge;

	svfm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	svfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// survivorship memory, one read and one write port
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= surv_mem[AW'(s_tdata[5:0])];
		end
		if (mem_we) begin
			surv_mem[AW'(col_q)] <= res_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= s_tdata[5:0];
			m_q <= s_tdata[37:6];
			age_q <= s_tuser[2:0];
			first_q <= s_tuser[3];
			inf_q <= s_tuser[4];
			in_range_q <= 32'(s_tdata[5:0]) < 32'(NUM_COLUMNS);
		end
		case (state_q)
			ST_READ: begin
				prior_q <= first_q ? svfm_pkg::ONE31 : rdata_q;
				sl_prod_s1 <= 64'(slope) * 64'(m_q);
			end
			ST_PREP: begin
				d24_q <= d30[34] ? '0 : d30[32:6];
				x_q <= x_w;
				use_exp_q <= method_q == svfm_pkg::MethodConst &&
					!(infant && !a0_q[31] && a0_q != 32'sd0);
			end
			ST_DEN: begin
				den_prod_s1 <= 59'(d24_q) * 59'(m_q);
			end
			ST_CHOOSE: begin
				err_q <= !in_range_q || age_q[2];
				wr_q <= in_range_q && !age_q[2];
				p_q <= svfm_pkg::ONE62;
				b_q <= '0;
				if (!in_range_q) begin
					res_q <= '0;
				end else if (age_q[2]) begin
					res_q <= prior_q;
				end else if (inf_q) begin
					res_q <= '0;
				end else if (use_exp_q) begin
					if (x_q[34:29] != 6'd0) begin
						res_q <= '0;
					end
				end else if (num_ge) begin
					res_q <= '0;
				end
			end
			ST_DIVW: begin
				if (div_done) begin
					q_q <= div_quot;
				end
			end
			ST_SCALE: begin
				scale_s1 <= 63'(prior_q) * 63'(svfm_pkg::ONE31 - 32'(q_q));
			end
			ST_SCALEF: begin
				res_q <= scale_s1[62:31];
			end
			ST_EXP: begin
				if (!xl[b_q]) begin
					b_q <= b_q + 5'd1;
				end
			end
			ST_EXPW: begin
				if (mul_done) begin
					p_q <= mul_res;
					b_q <= b_q + 5'd1;
				end
			end
			ST_EXPFW: begin
				if (mul_done) begin
					res_q <= mul_res[31:0];
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_col_q <= col_q;
			out_surv_q <= res_q;
			out_err_q <= err_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			method_q <= svfm_pkg::MethodConst;
			sex_q <= 1'b0;
			a0_q <= -32'sd1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					svfm_pkg::CfgMethod: method_q <= cfg_data[1:0];
					svfm_pkg::CfgSex: sex_q <= cfg_data[0];
					svfm_pkg::CfgSep: a0_q <= $signed(cfg_data);
					default: begin
					end
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DEN;
				ST_DEN: state_q <= ST_CHOOSE;
				ST_CHOOSE: begin
					if (div_start) begin
						state_q <= ST_DIVW;
					end else if (in_range_q && !age_q[2] && !inf_q && use_exp_q &&
							x_q[34:29] == 6'd0) begin
						state_q <= ST_EXP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_SCALEF;
				ST_SCALEF: state_q <= ST_DONE;
				ST_EXP: begin
					if (xl[b_q]) begin
						state_q <= ST_EXPW;
					end else if (b_q == 5'(svfm_pkg::ExpBits - 1)) begin
						state_q <= ST_EXPF;
					end
				end
				ST_EXPW: begin
					if (mul_done) begin
						state_q <= (b_q == 5'(svfm_pkg::ExpBits - 1)) ? ST_EXPF : ST_EXP;
					end
				end
				ST_EXPF: state_q <= ST_EXPFW;
				ST_EXPFW: begin
					if (mul_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_surv_q, out_col_q};
	assign m_tuser = out_err_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item accepted while another is in work");

	a_surv_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[37:6] <= svfm_pkg::ONE31)
		else $error("survivorship above one");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> in_range_q && !err_q && res_q <= svfm_pkg::ONE31)
		else $error("bad survivorship write");

	a_div_operands: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> num < den)
		else $error("divider started with quotient of one or more");

endmodule
`default_nettype wire

/* hw/rtl/svfm_mul.sv */
`default_nettype none
// (a*b) >> 62 from four 32x32 partial products
module svfm_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sel_s1;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  op_a;
	logic [31:0]  op_b;
	logic [127:0] pp_sh;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
			2'd1: begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
			2'd2: begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
			default: begin op_a = a_q[63:32]; op_b = b_q[63:32]; end
		endcase
		case (sel_s1)
			2'd0: pp_sh = {64'd0, pp_s1};
			2'd3: pp_sh = {pp_s1, 64'd0};
			default: pp_sh = {32'd0, pp_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q && cnt_q != 3'd4) begin
			pp_s1 <= 64'(op_a) * 64'(op_b);
			sel_s1 <= cnt_q[1:0];
		end
		if (start) begin
			acc_q <= '0;
		end else if (busy_q && cnt_q != 3'd0) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res = acc_q[125:62];

endmodule
`default_nettype wire

/* hw/rtl/svfm_div.sv */
`default_nettype none
// restoring divider, one quotient bit a cycle, needs num < den
module svfm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [59:0] num,
	input  wire logic [59:0] den,
	output logic             done,
	output logic [svfm_pkg::QBits-1:0] quot
);

	logic [59:0] rem_q;
	logic [59:0] den_q;
	logic [svfm_pkg::QBits-1:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [60:0] r2;
	logic        fit;

	assign r2 = {rem_q, 1'b0};
	assign fit = r2 >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? 60'(r2 - {1'b0, den_q}) : r2[59:0];
			quot_q <= {quot_q[svfm_pkg::QBits-2:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(svfm_pkg::QBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire
